// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the detector RTL.
// Define NO_ASSERTIONS to compile the checks out; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define VSGD_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define VSGD_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define VSGD_ASSERT(label, prop, msg)
`define VSGD_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

// ===== rtl/vsgd_pkg.sv =====
// Shared types, codes and defaults of the vertical stroke gesture detector.
// No dependencies; imported by every module of the block.
`default_nettype none
package vsgd_pkg;
	localparam int SAMPLE_BITS_DEF = 10;
	localparam int TIME_BITS_DEF   = 32;
	localparam int LIMIT_BITS      = 16;
	localparam int CFG_INDEX_BITS  = 3;

	localparam int IDLE_BAND_LOW_RST  = 395;
	localparam int IDLE_BAND_HIGH_RST = 425;
	localparam int STOP_BAND_LOW_RST  = 405;
	localparam int STOP_BAND_HIGH_RST = 410;
	localparam int MAX_STROKE_RST     = 750;
	localparam int MAX_SPAN_RST       = 2000;
	localparam int MAX_AGE_RST        = 500;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		CFG_IDLE_BAND_LOW  = 3'd0,
		CFG_IDLE_BAND_HIGH = 3'd1,
		CFG_STOP_BAND_LOW  = 3'd2,
		CFG_STOP_BAND_HIGH = 3'd3,
		CFG_MAX_STROKE     = 3'd4,
		CFG_MAX_SPAN       = 3'd5,
		CFG_MAX_AGE        = 3'd6
	} cfg_index_t;

	typedef enum logic [2:0] {
		DIR_IDLE = 3'b001,
		DIR_UP   = 3'b010,
		DIR_DOWN = 3'b100
	} dir_t;

	localparam logic [1:0] DIRCODE_IDLE = 2'b00;
	localparam logic [1:0] DIRCODE_UP   = 2'b01;
	localparam logic [1:0] DIRCODE_DOWN = 2'b11;

	typedef enum logic [2:0] {
		REASON_OK        = 3'd0,
		REASON_MOVING    = 3'd1,
		REASON_ORDER     = 3'd2,
		REASON_UP_LONG   = 3'd3,
		REASON_DOWN_LONG = 3'd4,
		REASON_SPAN_LONG = 3'd5,
		REASON_TOO_OLD   = 3'd6
	} reason_t;

	typedef struct packed {
		logic [1:0] direction;
		logic       gesture_ok;
		reason_t    reason;
	} trk_result_t;
endpackage
`default_nettype wire

// ===== rtl/vsgd_cfg_regs.sv =====
// Configuration register file: band edges and time limits.
// Depends on vsgd_pkg for register indexes and reset values.
`default_nettype none
module vsgd_cfg_regs
	import vsgd_pkg::*;
#(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_valid,
	output logic                           cfg_ready,
	input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  wire logic [LIMIT_BITS-1:0]     cfg_data,
	output logic [SAMPLE_BITS-1:0]         idle_low,
	output logic [SAMPLE_BITS-1:0]         idle_high,
	output logic [SAMPLE_BITS-1:0]         stop_low,
	output logic [SAMPLE_BITS-1:0]         stop_high,
	output logic [LIMIT_BITS-1:0]          max_stroke,
	output logic [LIMIT_BITS-1:0]          max_span,
	output logic [LIMIT_BITS-1:0]          max_age
);
	logic [SAMPLE_BITS-1:0] idle_low_q, idle_high_q, stop_low_q, stop_high_q;
	logic [LIMIT_BITS-1:0]  max_stroke_q, max_span_q, max_age_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_low_q   <= SAMPLE_BITS'(IDLE_BAND_LOW_RST);
			idle_high_q  <= SAMPLE_BITS'(IDLE_BAND_HIGH_RST);
			stop_low_q   <= SAMPLE_BITS'(STOP_BAND_LOW_RST);
			stop_high_q  <= SAMPLE_BITS'(STOP_BAND_HIGH_RST);
			max_stroke_q <= LIMIT_BITS'(MAX_STROKE_RST);
			max_span_q   <= LIMIT_BITS'(MAX_SPAN_RST);
			max_age_q    <= LIMIT_BITS'(MAX_AGE_RST);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index_t'(cfg_index))
				CFG_IDLE_BAND_LOW:  idle_low_q   <= cfg_data[SAMPLE_BITS-1:0];
				CFG_IDLE_BAND_HIGH: idle_high_q  <= cfg_data[SAMPLE_BITS-1:0];
				CFG_STOP_BAND_LOW:  stop_low_q   <= cfg_data[SAMPLE_BITS-1:0];
				CFG_STOP_BAND_HIGH: stop_high_q  <= cfg_data[SAMPLE_BITS-1:0];
				CFG_MAX_STROKE:     max_stroke_q <= cfg_data;
				CFG_MAX_SPAN:       max_span_q   <= cfg_data;
				CFG_MAX_AGE:        max_age_q    <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign idle_low   = idle_low_q;
	assign idle_high  = idle_high_q;
	assign stop_low   = stop_low_q;
	assign stop_high  = stop_high_q;
	assign max_stroke = max_stroke_q;
	assign max_span   = max_span_q;
	assign max_age    = max_age_q;
endmodule
`default_nettype wire

// ===== rtl/vsgd_tracker.sv =====
// Stroke tracker: motion state, stroke timestamps and the gesture check.
// Depends on vsgd_pkg for the direction, reason and result types.
`default_nettype none
module vsgd_tracker
	import vsgd_pkg::*;
#(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
	parameter int TIME_BITS   = TIME_BITS_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   advance,
	input  wire logic [SAMPLE_BITS-1:0] sample,
	input  wire logic [TIME_BITS-1:0]   now_ms,
	input  wire logic [SAMPLE_BITS-1:0] idle_low,
	input  wire logic [SAMPLE_BITS-1:0] idle_high,
	input  wire logic [SAMPLE_BITS-1:0] stop_low,
	input  wire logic [SAMPLE_BITS-1:0] stop_high,
	input  wire logic [LIMIT_BITS-1:0]  max_stroke,
	input  wire logic [LIMIT_BITS-1:0]  max_span,
	input  wire logic [LIMIT_BITS-1:0]  max_age,
	output trk_result_t                 result
);
	dir_t                 dir_q, dir_d;
	logic [TIME_BITS-1:0] up_start_q, up_end_q, up_len_q;
	logic [TIME_BITS-1:0] down_start_q, down_end_q, down_len_q;
	logic [TIME_BITS-1:0] up_start_d, up_end_d, up_len_d;
	logic [TIME_BITS-1:0] down_start_d, down_end_d, down_len_d;
	logic [TIME_BITS-1:0] span, age;
	logic                 in_idle, in_stop;

	always_comb begin
		dir_d        = dir_q;
		up_start_d   = up_start_q;
		up_end_d     = up_end_q;
		up_len_d     = up_len_q;
		down_start_d = down_start_q;
		down_end_d   = down_end_q;
		down_len_d   = down_len_q;
		in_idle      = (sample > idle_low) && (sample < idle_high);
		in_stop      = (sample > stop_low) && (sample < stop_high);
		case (dir_q)
			DIR_IDLE: begin
				if (!in_idle) begin
					if (sample <= idle_low) begin
						dir_d      = DIR_UP;
						up_start_d = now_ms;
						up_end_d   = '0;
						up_len_d   = '0;
					end else begin
						dir_d        = DIR_DOWN;
						down_start_d = now_ms;
						down_end_d   = '0;
						down_len_d   = '0;
					end
				end
			end
			DIR_UP: begin
				if (in_stop) begin
					dir_d    = DIR_IDLE;
					up_end_d = now_ms;
					up_len_d = now_ms - up_start_q;
				end
			end
			DIR_DOWN: begin
				if (in_stop) begin
					dir_d      = DIR_IDLE;
					down_end_d = now_ms;
					down_len_d = now_ms - down_start_q;
				end
			end
			default: dir_d = DIR_IDLE;
		endcase

		span = down_end_d - up_start_d;
		age  = now_ms - down_end_d;

		if (dir_d != DIR_IDLE) begin
			result.reason = REASON_MOVING;
		end else if (up_start_d > down_start_d) begin
			result.reason = REASON_ORDER;
		end else if (up_len_d > TIME_BITS'(max_stroke)) begin
			result.reason = REASON_UP_LONG;
		end else if (down_len_d > TIME_BITS'(max_stroke)) begin
			result.reason = REASON_DOWN_LONG;
		end else if (span > TIME_BITS'(max_span)) begin
			result.reason = REASON_SPAN_LONG;
		end else if (age > TIME_BITS'(max_age)) begin
			result.reason = REASON_TOO_OLD;
		end else begin
			result.reason = REASON_OK;
		end
		result.gesture_ok = (result.reason == REASON_OK);

		case (dir_d)
			DIR_UP:   result.direction = DIRCODE_UP;
			DIR_DOWN: result.direction = DIRCODE_DOWN;
			default:  result.direction = DIRCODE_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_q        <= DIR_IDLE;
			up_start_q   <= '0;
			up_end_q     <= '0;
			up_len_q     <= '0;
			down_start_q <= '0;
			down_end_q   <= '0;
			down_len_q   <= '0;
		end else if (advance) begin
			dir_q        <= dir_d;
			up_start_q   <= up_start_d;
			up_end_q     <= up_end_d;
			up_len_q     <= up_len_d;
			down_start_q <= down_start_d;
			down_end_q   <= down_end_d;
			down_len_q   <= down_len_d;
		end
	end
endmodule
`default_nettype wire

// ===== rtl/vertical_stroke_gesture_detector_top.sv =====
// A request is held in the input register, then its result in the output register;
// one request per cycle while the output is ready. The tracker check is combinational;
// the input stalls only while both registers are full and the output is not ready.
// Asynchronous active-low reset sets the motion state to idle, all stroke times to zero
// and the configuration registers to their defaults; no clearing pass is needed.
// Depends on vsgd_pkg, vsgd_cfg_regs, vsgd_tracker and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module vertical_stroke_gesture_detector_top
	import vsgd_pkg::*;
#(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
	parameter int TIME_BITS   = TIME_BITS_DEF
) (
	input  wire logic                                         clk,
	input  wire logic                                         arst_n,
	input  wire logic                                         s_tvalid,
	output logic                                              s_tready,
	// Fields from bit 0: sample, now_ms, zero padding.
	input  wire logic [((SAMPLE_BITS+TIME_BITS+7)/8)*8-1:0]   s_tdata,
	output logic                                              m_tvalid,
	input  wire logic                                         m_tready,
	// Fields from bit 0: sample_echo, direction, gesture_ok, fail_reason, zero padding.
	output logic [((SAMPLE_BITS+6+7)/8)*8-1:0]                m_tdata,
	input  wire logic                                         cfg_valid,
	output logic                                              cfg_ready,
	input  wire logic [CFG_INDEX_BITS-1:0]                    cfg_index,
	input  wire logic [LIMIT_BITS-1:0]                        cfg_data
);
	logic [SAMPLE_BITS-1:0] idle_low, idle_high, stop_low, stop_high;
	logic [LIMIT_BITS-1:0]  max_stroke, max_span, max_age;

	logic                   valid_s1;
	logic [SAMPLE_BITS-1:0] sample_s1;
	logic [TIME_BITS-1:0]   now_s1;
	logic                   out_valid_s2;
	logic [SAMPLE_BITS-1:0] sample_s2;
	trk_result_t            res_s2;
	trk_result_t            trk_res;
	logic                   advance;

	vsgd_cfg_regs #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.idle_low  (idle_low),
		.idle_high (idle_high),
		.stop_low  (stop_low),
		.stop_high (stop_high),
		.max_stroke(max_stroke),
		.max_span  (max_span),
		.max_age   (max_age)
	);

	vsgd_tracker #(
		.SAMPLE_BITS(SAMPLE_BITS),
		.TIME_BITS  (TIME_BITS)
	) u_tracker (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.sample    (sample_s1),
		.now_ms    (now_s1),
		.idle_low  (idle_low),
		.idle_high (idle_high),
		.stop_low  (stop_low),
		.stop_high (stop_high),
		.max_stroke(max_stroke),
		.max_span  (max_span),
		.max_age   (max_age),
		.result    (trk_res)
	);

	assign advance  = valid_s1 && (!out_valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			out_valid_s2 <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (advance) begin
				out_valid_s2 <= 1'b1;
			end else if (m_tready) begin
				out_valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			sample_s1 <= s_tdata[SAMPLE_BITS-1:0];
			now_s1    <= s_tdata[SAMPLE_BITS+TIME_BITS-1:SAMPLE_BITS];
		end
		if (advance) begin
			sample_s2 <= sample_s1;
			res_s2    <= trk_res;
		end
	end

	assign m_tvalid = out_valid_s2;

	always_comb begin
		m_tdata                                  = '0;
		m_tdata[SAMPLE_BITS-1:0]                 = sample_s2;
		m_tdata[SAMPLE_BITS+1:SAMPLE_BITS]       = res_s2.direction;
		m_tdata[SAMPLE_BITS+2]                   = res_s2.gesture_ok;
		m_tdata[SAMPLE_BITS+5:SAMPLE_BITS+3]     = res_s2.reason;
	end

	`VSGD_ASSERT(a_stall_cause, !s_tready |-> (valid_s1 && out_valid_s2 && !m_tready), "input stalled without a blocked output")
	`VSGD_ASSERT(a_s1_hold, (valid_s1 && !advance) |=> (valid_s1 && $stable(now_s1) && $stable(sample_s1)), "input stage lost a waiting request")
	`VSGD_ASSERT(a_result_load, advance |=> (out_valid_s2 && res_s2 == $past(trk_res)), "result register missed a finished request")
	`VSGD_ASSERT(a_ok_reason, out_valid_s2 |-> (res_s2.gesture_ok == (res_s2.reason == REASON_OK)), "pass flag disagrees with reason")
	`VSGD_ASSERT(a_moving_reason, (out_valid_s2 && res_s2.direction != DIRCODE_IDLE) |-> (res_s2.reason == REASON_MOVING), "moving result without moving reason")
	`VSGD_ASSERT_ALWAYS(a_reset_empty, !arst_n |-> (!valid_s1 && !out_valid_s2), "pipeline not empty in reset")
endmodule
`default_nettype wire
